// ===== rtl/ramc_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ramc_pkg: shared types, constants and microcode for the rational core
// Holds the action codes, the control word layout and the sequencer program.
// ---------------------------------------------------------------------------
package ramc_pkg;

    localparam int DEF_OPERAND_WIDTH = 16;
    localparam int RES_W             = 31;
    localparam int PC_W              = 5;

    typedef enum logic [1:0] {
        ACT_ADD = 2'd0,
        ACT_MUL = 2'd1,
        ACT_EQ  = 2'd2,
        ACT_NE  = 2'd3
    } t_action;

    typedef enum logic [4:0] {
        OP_NOP,
        OP_LDL,
        OP_LDR,
        OP_GCD_GO,
        OP_GCD_WAIT,
        OP_DVN_GO,
        OP_DVN_WAIT,
        OP_DVD_GO,
        OP_DVD_WAIT,
        OP_SAVL,
        OP_SAVR,
        OP_MLA,
        OP_MLB,
        OP_MLD,
        OP_MLN,
        OP_ADD,
        OP_FIN
    } t_uop;

    typedef enum logic [2:0] {
        C_NONE,
        C_ALWAYS,
        C_LBAD,
        C_RBAD,
        C_XZERO,
        C_CMP,
        C_EMPTY,
        C_MUL
    } t_cond;

    typedef struct packed {
        t_uop            op;
        t_cond           cond;
        logic [PC_W-1:0] target;
    } t_uword;

    // program labels
    localparam logic [PC_W-1:0] A_SAVL  = PC_W'(7);
    localparam logic [PC_W-1:0] A_LDR   = PC_W'(8);
    localparam logic [PC_W-1:0] A_SAVR  = PC_W'(15);
    localparam logic [PC_W-1:0] A_MLN   = PC_W'(22);
    localparam logic [PC_W-1:0] A_RED   = PC_W'(24);
    localparam logic [PC_W-1:0] A_FIN   = PC_W'(30);
    localparam logic [PC_W-1:0] A_NONE  = PC_W'(0);

    function automatic t_uword f_uw(t_uop op, t_cond c, logic [PC_W-1:0] t);
        t_uword w;
        w.op     = op;
        w.cond   = c;
        w.target = t;
        return w;
    endfunction

    function automatic t_uword f_ucode(logic [PC_W-1:0] pc);
        t_uword w;
        unique case (pc)
            // reduce left operand
            PC_W'(0):  w = f_uw(OP_LDL,      C_LBAD,   A_LDR);
            PC_W'(1):  w = f_uw(OP_GCD_GO,   C_XZERO,  A_SAVL);
            PC_W'(2):  w = f_uw(OP_GCD_WAIT, C_NONE,   A_NONE);
            PC_W'(3):  w = f_uw(OP_DVN_GO,   C_NONE,   A_NONE);
            PC_W'(4):  w = f_uw(OP_DVN_WAIT, C_NONE,   A_NONE);
            PC_W'(5):  w = f_uw(OP_DVD_GO,   C_NONE,   A_NONE);
            PC_W'(6):  w = f_uw(OP_DVD_WAIT, C_NONE,   A_NONE);
            PC_W'(7):  w = f_uw(OP_SAVL,     C_NONE,   A_NONE);
            // reduce right operand
            PC_W'(8):  w = f_uw(OP_LDR,      C_RBAD,   A_SAVR + PC_W'(1));
            PC_W'(9):  w = f_uw(OP_GCD_GO,   C_XZERO,  A_SAVR);
            PC_W'(10): w = f_uw(OP_GCD_WAIT, C_NONE,   A_NONE);
            PC_W'(11): w = f_uw(OP_DVN_GO,   C_NONE,   A_NONE);
            PC_W'(12): w = f_uw(OP_DVN_WAIT, C_NONE,   A_NONE);
            PC_W'(13): w = f_uw(OP_DVD_GO,   C_NONE,   A_NONE);
            PC_W'(14): w = f_uw(OP_DVD_WAIT, C_NONE,   A_NONE);
            PC_W'(15): w = f_uw(OP_SAVR,     C_NONE,   A_NONE);
            // dispatch
            PC_W'(16): w = f_uw(OP_NOP,      C_CMP,    A_FIN);
            PC_W'(17): w = f_uw(OP_NOP,      C_EMPTY,  A_FIN);
            // add
            PC_W'(18): w = f_uw(OP_MLA,      C_MUL,    A_MLN);
            PC_W'(19): w = f_uw(OP_MLB,      C_NONE,   A_NONE);
            PC_W'(20): w = f_uw(OP_ADD,      C_NONE,   A_NONE);
            PC_W'(21): w = f_uw(OP_MLD,      C_ALWAYS, A_RED);
            // multiply
            PC_W'(22): w = f_uw(OP_MLN,      C_NONE,   A_NONE);
            PC_W'(23): w = f_uw(OP_MLD,      C_NONE,   A_NONE);
            // reduce result
            PC_W'(24): w = f_uw(OP_GCD_GO,   C_XZERO,  A_FIN);
            PC_W'(25): w = f_uw(OP_GCD_WAIT, C_NONE,   A_NONE);
            PC_W'(26): w = f_uw(OP_DVN_GO,   C_NONE,   A_NONE);
            PC_W'(27): w = f_uw(OP_DVN_WAIT, C_NONE,   A_NONE);
            PC_W'(28): w = f_uw(OP_DVD_GO,   C_NONE,   A_NONE);
            PC_W'(29): w = f_uw(OP_DVD_WAIT, C_NONE,   A_NONE);
            default:   w = f_uw(OP_FIN,      C_NONE,   A_NONE);
        endcase
        return w;
    endfunction

endpackage

// ===== rtl/ramc_gcd.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ramc_gcd: iterative binary gcd
// One Stein step per cycle; result valid while not busy.
// ---------------------------------------------------------------------------
module ramc_gcd
    import ramc_pkg::*;
#(
    parameter int WIDTH = 2 * DEF_OPERAND_WIDTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_go,
    input  logic [WIDTH-1:0] i_a,
    input  logic [WIDTH-1:0] i_b,
    output logic             o_busy,
    output logic [WIDTH-1:0] o_g
);

    localparam int KW = $clog2(WIDTH + 1);

    logic             r_busy;
    logic [WIDTH-1:0] r_a;
    logic [WIDTH-1:0] r_b;
    logic [KW-1:0]    r_k;
    logic [WIDTH-1:0] r_g;
    logic             a_ge_b;

    assign a_ge_b = (r_a >= r_b);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_go) begin
            r_busy <= 1'b1;
            r_a    <= i_a;
            r_b    <= i_b;
            r_k    <= '0;
        end else if (r_busy) begin
            if (r_a == '0 || r_b == '0) begin
                r_busy <= 1'b0;
                r_g    <= (r_a | r_b) << r_k;
            end else if (!r_a[0] && !r_b[0]) begin
                r_a <= r_a >> 1;
                r_b <= r_b >> 1;
                r_k <= r_k + KW'(1);
            end else if (!r_a[0]) begin
                r_a <= r_a >> 1;
            end else if (!r_b[0]) begin
                r_b <= r_b >> 1;
            end else if (a_ge_b) begin
                r_a <= r_a - r_b;
            end else begin
                r_b <= r_b - r_a;
            end
        end
    end

    assign o_busy = r_busy;
    assign o_g    = r_g;

endmodule

// ===== rtl/ramc_div.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ramc_div: restoring divider
// One quotient bit per cycle; the quotient is WIDTH bits wide.
// ---------------------------------------------------------------------------
module ramc_div
    import ramc_pkg::*;
#(
    parameter int WIDTH = 2 * DEF_OPERAND_WIDTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_go,
    input  logic [WIDTH-1:0] i_dividend,
    input  logic [WIDTH-1:0] i_divisor,
    output logic             o_busy,
    output logic [WIDTH-1:0] o_quot
);

    localparam int CW = $clog2(WIDTH + 1);

    logic             r_busy;
    logic [CW-1:0]    r_cnt;
    logic [WIDTH-1:0] r_rem;
    logic [WIDTH-1:0] r_q;
    logic [WIDTH-1:0] r_dvs;
    logic [WIDTH:0]   rem_sh;
    logic [WIDTH:0]   diff;

    assign rem_sh = {r_rem, r_q[WIDTH-1]};
    assign diff   = rem_sh - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_go) begin
            r_busy <= 1'b1;
            r_cnt  <= CW'(WIDTH);
            r_rem  <= '0;
            r_q    <= i_dividend;
            r_dvs  <= i_divisor;
        end else if (r_busy) begin
            if (!diff[WIDTH]) begin
                r_rem <= diff[WIDTH-1:0];
                r_q   <= {r_q[WIDTH-2:0], 1'b1};
            end else begin
                r_rem <= rem_sh[WIDTH-1:0];
                r_q   <= {r_q[WIDTH-2:0], 1'b0};
            end
            r_cnt <= r_cnt - CW'(1);
            if (r_cnt == CW'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_q;

endmodule

// ===== rtl/rational_add_multiply_compare_core.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rational_add_multiply_compare_core: rational add / multiply / compare
// Microcoded sequencer driving a small datapath with a gcd and a divider.
// ---------------------------------------------------------------------------
// An item is taken when start is high and busy is low. Its single result word
// appears once the sequencer reaches its final step; o_valid is high with it
// for exactly one cycle and the receiver cannot stall it. One item is in work
// at a time. The sequencer walks up to three fraction reductions. Each is a
// binary gcd on 2*OPERAND_WIDTH-bit words, one step per cycle, followed by
// two restoring divides of the numerator and the denominator by the gcd, with
// load, start and wait steps between. A compare of two empty operands skips
// both reductions and goes from the dispatch step straight to the final step.
// A zero numerator skips its reduction. busy drops in the cycle the result is
// shown, so the next start may be given then.
// ---------------------------------------------------------------------------
module rational_add_multiply_compare_core
    import ramc_pkg::*;
#(
    parameter int OPERAND_WIDTH = DEF_OPERAND_WIDTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [1:0]                      i_action,
    input  logic signed [OPERAND_WIDTH-1:0] i_left_num,
    input  logic signed [OPERAND_WIDTH-1:0] i_left_den,
    input  logic signed [OPERAND_WIDTH-1:0] i_right_num,
    input  logic signed [OPERAND_WIDTH-1:0] i_right_den,
    output logic                            o_valid,
    output logic [RES_W-1:0]                o_result_num,
    output logic [RES_W-1:0]                o_result_den,
    output logic                            o_result_empty,
    output logic                            o_compare_true
);

    localparam int W  = OPERAND_WIDTH;
    localparam int PW = 2 * OPERAND_WIDTH;

    logic            r_busy;
    logic [PC_W-1:0] r_pc;
    logic [PC_W-1:0] n_pc;
    t_action         r_act;
    logic [W-1:0]    r_ln;
    logic [W-1:0]    r_ld;
    logic [W-1:0]    r_rn;
    logic [W-1:0]    r_rd;
    logic            r_lok;
    logic            r_rok;
    logic [PW-1:0]   r_x;
    logic [PW-1:0]   r_y;

    logic            r_valid;
    logic [RES_W-1:0] r_num;
    logic [RES_W-1:0] r_den;
    logic            r_empty;
    logic            r_cmp;

    t_uword          uw;
    logic            take;
    logic            stall;
    logic            accept;
    logic            both;
    logic            same;
    logic            gcd_go;
    logic            gcd_busy;
    logic [PW-1:0]   gcd_g;
    logic            div_go;
    logic            div_busy;
    logic [PW-1:0]   div_q;
    logic [PW-1:0]   div_dividend;
    logic [W-1:0]    mul_a;
    logic [W-1:0]    mul_b;
    logic [PW-1:0]   mul_p;

    assign accept = start && !r_busy;
    assign uw     = f_ucode(r_pc);
    assign both   = r_lok && r_rok;
    assign same   = (r_ln == r_rn) && (r_ld == r_rd);

    always_comb begin
        unique case (uw.cond)
            C_NONE:   take = 1'b0;
            C_ALWAYS: take = 1'b1;
            C_LBAD:   take = !r_lok;
            C_RBAD:   take = !r_rok;
            C_XZERO:  take = (r_x == '0);
            C_CMP:    take = r_act[1];
            C_EMPTY:  take = !both;
            C_MUL:    take = (r_act == ACT_MUL);
        endcase
    end

    assign stall = ((uw.op == OP_GCD_WAIT) && gcd_busy) ||
                   (((uw.op == OP_DVN_WAIT) || (uw.op == OP_DVD_WAIT)) && div_busy);

    always_comb begin
        priority if (stall) begin
            n_pc = r_pc;
        end else if (take) begin
            n_pc = uw.target;
        end else begin
            n_pc = r_pc + PC_W'(1);
        end
    end

    assign gcd_go       = r_busy && (uw.op == OP_GCD_GO) && (r_x != '0);
    assign div_go       = r_busy && ((uw.op == OP_DVN_GO) || (uw.op == OP_DVD_GO));
    assign div_dividend = (uw.op == OP_DVD_GO) ? r_y : r_x;

    always_comb begin
        unique case (uw.op)
            OP_MLA: begin
                mul_a = r_ln;
                mul_b = r_rd;
            end
            OP_MLB: begin
                mul_a = r_ld;
                mul_b = r_rn;
            end
            OP_MLN: begin
                mul_a = r_ln;
                mul_b = r_rn;
            end
            default: begin
                mul_a = r_ld;
                mul_b = r_rd;
            end
        endcase
    end

    assign mul_p = PW'(mul_a) * PW'(mul_b);

    ramc_gcd #(
        .WIDTH (PW)
    ) u_gcd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (gcd_go),
        .i_a     (r_x),
        .i_b     (r_y),
        .o_busy  (gcd_busy),
        .o_g     (gcd_g)
    );

    ramc_div #(
        .WIDTH (PW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_go       (div_go),
        .i_dividend (div_dividend),
        .i_divisor  (gcd_g),
        .o_busy     (div_busy),
        .o_quot     (div_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_pc    <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= r_busy && (uw.op == OP_FIN);
            if (accept) begin
                r_busy <= 1'b1;
                r_pc   <= '0;
                r_act  <= t_action'(i_action);
                r_ln   <= i_left_num;
                r_ld   <= i_left_den;
                r_rn   <= i_right_num;
                r_rd   <= i_right_den;
                r_lok  <= !i_left_num[W-1] && !i_left_den[W-1] && (i_left_den != '0);
                r_rok  <= !i_right_num[W-1] && !i_right_den[W-1] && (i_right_den != '0);
            end else if (r_busy) begin
                r_pc <= n_pc;
                unique case (uw.op)
                    OP_LDL: begin
                        r_x <= PW'(r_ln);
                        r_y <= PW'(r_ld);
                    end
                    OP_LDR: begin
                        r_x <= PW'(r_rn);
                        r_y <= PW'(r_rd);
                    end
                    OP_DVN_WAIT: begin
                        if (!div_busy) begin
                            r_x <= div_q;
                        end
                    end
                    OP_DVD_WAIT: begin
                        if (!div_busy) begin
                            r_y <= div_q;
                        end
                    end
                    OP_SAVL: begin
                        r_ln <= r_x[W-1:0];
                        r_ld <= r_y[W-1:0];
                    end
                    OP_SAVR: begin
                        r_rn <= r_x[W-1:0];
                        r_rd <= r_y[W-1:0];
                    end
                    OP_MLA, OP_MLN: begin
                        r_x <= mul_p;
                    end
                    OP_MLB, OP_MLD: begin
                        r_y <= mul_p;
                    end
                    OP_ADD: begin
                        r_x <= r_x + r_y;
                    end
                    OP_FIN: begin
                        r_busy  <= 1'b0;
                        if (r_act[1]) begin
                            r_num   <= '0;
                            r_den   <= '0;
                            r_empty <= 1'b0;
                            r_cmp   <= (r_act == ACT_EQ) ? (both && same) : (both && !same);
                        end else if (!both) begin
                            r_num   <= '0;
                            r_den   <= '0;
                            r_empty <= 1'b1;
                            r_cmp   <= 1'b0;
                        end else begin
                            r_num   <= RES_W'(r_x);
                            r_den   <= RES_W'(r_y);
                            r_empty <= 1'b0;
                            r_cmp   <= 1'b0;
                        end
                    end
                    OP_NOP, OP_GCD_GO, OP_GCD_WAIT, OP_DVN_GO, OP_DVD_GO: begin
                    end
                endcase
            end
        end
    end

    assign busy           = r_busy;
    assign o_valid        = r_valid;
    assign o_result_num   = r_num;
    assign o_result_den   = r_den;
    assign o_result_empty = r_empty;
    assign o_compare_true = r_cmp;

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> busy)
        else $error("accepted word did not raise busy");

    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result shown while still busy");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result_empty) |-> (o_result_num == '0 && o_result_den == '0
                                         && !o_compare_true))
        else $error("empty result carries nonzero fields");

    a_cmp_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_compare_true) |-> (o_result_num == '0 && o_result_den == '0))
        else $error("compare result carries fraction fields");

    a_unit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (gcd_go |-> !gcd_busy) and (div_go |-> !div_busy))
        else $error("unit started while busy");

endmodule

// ===== bench/rational_add_multiply_compare_core_test.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rational_add_multiply_compare_core_test: bench for the rational core
// Sends directed and random fraction words through the start/busy port and
// checks every result word against a local gcd-based fraction predictor.
// ---------------------------------------------------------------------------
module rational_add_multiply_compare_core_test
    import ramc_pkg::*;
();

    localparam int OPW        = DEF_OPERAND_WIDTH;
    localparam int STALL_MAX  = 4000;
    localparam int TAIL_CYCLES = 500;

    typedef struct {
        logic [63:0] num;
        logic [63:0] den;
        bit          empty;
    } t_frac;

    typedef struct {
        logic [RES_W-1:0] num;
        logic [RES_W-1:0] den;
        logic             empty;
        logic             cmp_true;
    } t_result;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  start       = 1'b0;
    logic [1:0]            i_action    = '0;
    logic signed [OPW-1:0] i_left_num  = '0;
    logic signed [OPW-1:0] i_left_den  = '0;
    logic signed [OPW-1:0] i_right_num = '0;
    logic signed [OPW-1:0] i_right_den = '0;
    logic                  busy;
    logic                  o_valid;
    logic [RES_W-1:0]      o_result_num;
    logic [RES_W-1:0]      o_result_den;
    logic                  o_result_empty;
    logic                  o_compare_true;

    t_result pending_results[$];
    int      mismatch_count = 0;
    int      stall_cycles   = 0;
    bit      idle_enable    = 1'b1;

    rational_add_multiply_compare_core #(
        .OPERAND_WIDTH(OPW)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_action       (i_action),
        .i_left_num     (i_left_num),
        .i_left_den     (i_left_den),
        .i_right_num    (i_right_num),
        .i_right_den    (i_right_den),
        .o_valid        (o_valid),
        .o_result_num   (o_result_num),
        .o_result_den   (o_result_den),
        .o_result_empty (o_result_empty),
        .o_compare_true (o_compare_true)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [63:0] gcd64(logic [63:0] a, logic [63:0] b);
        logic [63:0] t;
        if (a == 0 || b == 0)
            return 64'd1;
        while (b != 0) begin
            t = a % b;
            a = b;
            b = t;
        end
        return a;
    endfunction

    function automatic t_frac reduce_frac(logic [63:0] num, logic [63:0] den, bit ok);
        t_frac       f;
        logic [63:0] g;
        f.num   = '0;
        f.den   = '0;
        f.empty = 1'b1;
        if (ok) begin
            g       = gcd64(num, den);
            f.num   = num / g;
            f.den   = den / g;
            f.empty = 1'b0;
        end
        return f;
    endfunction

    function automatic t_frac norm_operand(logic [OPW-1:0] n, logic [OPW-1:0] d);
        return reduce_frac(64'(n), 64'(d), !n[OPW-1] && !d[OPW-1] && d != 0);
    endfunction

    function automatic t_result predict_result(t_action act,
                                               logic [OPW-1:0] ln, logic [OPW-1:0] ld,
                                               logic [OPW-1:0] rn, logic [OPW-1:0] rd);
        t_frac   a;
        t_frac   b;
        t_frac   r;
        t_result res;
        bit      both;
        bit      same;
        a    = norm_operand(ln, ld);
        b    = norm_operand(rn, rd);
        both = !a.empty && !b.empty;
        same = (a.num == b.num) && (a.den == b.den);
        res.num      = '0;
        res.den      = '0;
        res.empty    = 1'b0;
        res.cmp_true = 1'b0;
        case (act)
            ACT_ADD, ACT_MUL: begin
                if (act == ACT_ADD)
                    r = reduce_frac(a.num * b.den + a.den * b.num, a.den * b.den, both);
                else
                    r = reduce_frac(a.num * b.num, a.den * b.den, both);
                res.num   = r.num[RES_W-1:0];
                res.den   = r.den[RES_W-1:0];
                res.empty = r.empty;
            end
            ACT_EQ: res.cmp_true = both && same;
            default: res.cmp_true = both && !same;
        endcase
        return res;
    endfunction

    task automatic report_mismatch(string what, longint want, longint got);
        $display("mismatch at %0t: %s expected %0d got %0d", $realtime, what, want, got);
        mismatch_count++;
    endtask

    always @(posedge i_clk) begin : check_results
        t_result want;
        if (i_rst_n && o_valid) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result word, num", 0, o_result_num);
            end else begin
                want = pending_results.pop_front();
                if (o_result_num !== want.num)
                    report_mismatch("result_num", want.num, o_result_num);
                if (o_result_den !== want.den)
                    report_mismatch("result_den", want.den, o_result_den);
                if (o_result_empty !== want.empty)
                    report_mismatch("result_empty", want.empty, o_result_empty);
                if (o_compare_true !== want.cmp_true)
                    report_mismatch("compare_true", want.cmp_true, o_compare_true);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((start && busy === 1'b0) || o_valid === 1'b1)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_MAX) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // start stays high between back-to-back words; dropped only for a gap
    task automatic send_word(input t_action act, input int ln, input int ld,
                             input int rn, input int rd);
        int gap;
        if (idle_enable && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 18);
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start       <= 1'b1;
        i_action    <= act;
        i_left_num  <= OPW'(ln);
        i_left_den  <= OPW'(ld);
        i_right_num <= OPW'(rn);
        i_right_den <= OPW'(rd);
        do @(posedge i_clk); while (busy !== 1'b0);
        pending_results.push_back(predict_result(act, OPW'(ln), OPW'(ld),
                                                 OPW'(rn), OPW'(rd)));
    endtask

    task automatic test_operand_extremes();
        send_word(ACT_ADD, 32767, 32766, 32765, 32767);
        send_word(ACT_MUL, 32767, 1, 32767, 1);
        send_word(ACT_ADD, 32767, 1, 32767, 1);
        send_word(ACT_MUL, 1, 32767, 1, 32767);
        send_word(ACT_ADD, 32767, 32767, 1, 1);
        send_word(ACT_MUL, 12, 18, 9, 6);
    endtask

    task automatic test_empty_operands();
        send_word(ACT_ADD, -32768, 1, 1, 1);
        send_word(ACT_MUL, 1, 0, 1, 1);
        send_word(ACT_ADD, 1, 1, 1, -1);
        send_word(ACT_MUL, 1, 1, -1, 5);
        send_word(ACT_ADD, 1, -32768, 0, 0);
        send_word(ACT_EQ, -1, 2, -1, 2);
        send_word(ACT_NE, 3, 4, 3, 0);
    endtask

    task automatic test_zero_numerators();
        send_word(ACT_ADD, 0, 3, 0, 5);
        send_word(ACT_MUL, 0, 3, 0, 5);
        send_word(ACT_EQ, 0, 3, 0, 5);
        send_word(ACT_EQ, 0, 7, 0, 7);
        send_word(ACT_NE, 0, 3, 0, 5);
        send_word(ACT_ADD, 0, 32767, 5, 10);
    endtask

    task automatic test_compare_actions();
        send_word(ACT_EQ, 2, 4, 1, 2);
        send_word(ACT_EQ, 32767, 32766, 32767, 32766);
        send_word(ACT_NE, 2, 4, 1, 2);
        send_word(ACT_NE, 3, 4, 1, 2);
        send_word(ACT_EQ, 3, 4, 1, 2);
    endtask

    task automatic pick_operand(output int num, output int den);
        int mode;
        mode = $urandom_range(0, 9);
        case (mode)
            0: begin
                num = $urandom_range(0, 65535);
                den = $urandom_range(0, 65535);
            end
            1: begin
                num = 0;
                den = $urandom_range(1, 32767);
            end
            2, 3, 4, 5: begin
                num = $urandom_range(0, 20);
                den = $urandom_range(1, 20);
            end
            9: begin
                num = $urandom_range(0, 32767);
                den = $urandom_range(1, 32767);
                if ($urandom_range(0, 1))
                    den = -$urandom_range(0, 32768);
                else
                    num = -$urandom_range(1, 32768);
            end
            default: begin
                num = $urandom_range(0, 32767);
                den = $urandom_range(1, 32767);
            end
        endcase
    endtask

    task automatic test_random_traffic(input int count);
        t_action act;
        int      ln;
        int      ld;
        int      rn;
        int      rd;
        int      k;
        for (int i = 0; i < count; i++) begin
            act = t_action'($urandom_range(0, 3));
            pick_operand(ln, ld);
            pick_operand(rn, rd);
            // scaled copy of the left operand so equal tests hit both outcomes
            if ($urandom_range(0, 2) == 0 && ln >= 0 && ld >= 1 && ln <= 32767
                    && ld <= 32767) begin
                k  = $urandom_range(1, 32767 / (ln > ld ? (ln > 0 ? ln : 1) : ld));
                rn = ln * k;
                rd = ld * k;
            end
            send_word(act, ln, ld, rn, rd);
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_operand_extremes();
        test_empty_operands();
        test_zero_numerators();
        test_compare_actions();
        test_random_traffic(800);
        idle_enable = 1'b0;
        test_random_traffic(200);
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/ramc_pkg.sv
rtl/ramc_gcd.sv
rtl/ramc_div.sv
rtl/rational_add_multiply_compare_core.sv
bench/rational_add_multiply_compare_core_test.sv
